// ----- sv/birth_death_first_passage_sim_defines.svh -----
// ----------------------------------------------------------------------------
// birth_death_first_passage_sim_defines
// Assertion macros used by the birth-death passage simulator.
// ----------------------------------------------------------------------------
`ifndef BIRTH_DEATH_FIRST_PASSAGE_SIM_DEFINES_SVH
`define BIRTH_DEATH_FIRST_PASSAGE_SIM_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BD_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define BD_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define BD_ASSERT_IMP(label, clk, rst, a, c, msg)
`define BD_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

// ----- sv/bdfps_pkg.sv -----
// ----------------------------------------------------------------------------
// bdfps_pkg
// Shared constants and register indexes of the birth-death passage simulator.
// ----------------------------------------------------------------------------
package bdfps_pkg;
  localparam logic [1:0] REG_DECAY  = 2'd0;
  localparam logic [1:0] REG_GROWTH = 2'd1;
  localparam logic [1:0] REG_DIR    = 2'd2;
  localparam logic [1:0] REG_RUNS   = 2'd3;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [47:0] MASK48    = {48{1'b1}};
  localparam logic [62:0] MASK63    = {63{1'b1}};
endpackage

// ----- sv/birth_death_first_passage_sim.sv -----
// ----------------------------------------------------------------------------
// birth_death_first_passage_sim
// Stochastic birth-death chain stepper with first-passage statistics.
// ----------------------------------------------------------------------------
// Each input beat carries two Q0.32 random fractions and advances the chain
// by one stochastic step. When the count reaches the target, one output beat
// carries the passage time; the last run of a batch also carries mean,
// variance and Fano factor. Beats with a zero fraction are dropped and the
// block is ready again in the next cycle.
// The block works on one item at a time. Sequencer phases: a rate step,
// a logarithm (24 bits, a square and a normalize step each), a scaling
// step, a restoring divide by the total rate, and direction and advance
// bookkeeping for a step that ends no run. A zero total rate ends the
// step in the rate phase. A finishing run adds square, sums and output
// steps; at batch end two divides (mean, then second moment), a mean
// square, a variance step and a Fano divide come before the output.
// The result sits in an output register; a stalled receiver holds it, and
// the next item is taken only after the result is gone. Reset loads register
// defaults, starts a forward run at the start count and clears all sums.
// Configuration beats are accepted only while the sequencer is idle.
// ----------------------------------------------------------------------------
`include "birth_death_first_passage_sim_defines.svh"
module birth_death_first_passage_sim
  import bdfps_pkg::*;
#(
  parameter int SITES       = 13,
  parameter int START_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] rand_time,
  input  logic [31:0] rand_dir,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] passage_time,
  output logic [15:0] run_index,
  output logic        batch_done,
  output logic [47:0] mean_time,
  output logic [62:0] time_variance,
  output logic [31:0] fano_ratio,
  output logic        time_overflow
);
  localparam logic [3:0] START4 = 4'(START_COUNT);
  localparam logic [3:0] SITES4 = 4'(SITES);

  typedef enum logic [4:0] {
    S_IDLE, S_RATE, S_LOGM, S_LOGN, S_LN, S_DIVR, S_DIR, S_ADV,
    S_SQA, S_SQB, S_SQC, S_SQD, S_SUM, S_MEAN, S_M2, S_MSQA, S_MSQB,
    S_MSQC, S_MSQD, S_VAR, S_FANO, S_OUT
  } state_t;

  state_t state;
  logic [23:0] decay_rate, growth_rate;
  logic        direction_mode;
  logic [15:0] num_runs;
  logic [3:0]  unit_count;
  logic [47:0] elapsed_time;
  logic [15:0] runs_done;
  logic [63:0] time_sum, time_square_sum;
  logic        overflow_seen;

  logic [31:0] r2;
  logic [28:0] decay, total;
  logic [4:0]  lpos;
  logic [32:0] m;
  logic [23:0] frac;
  logic [4:0]  cnt;
  logic [6:0]  dcnt;
  logic [63:0] dnum, dquo;
  logic [64:0] drem;
  logic [63:0] dden;
  logic [63:0] acc;
  logic [1:0]  sat_hi;
  logic        batch_end, sat;
  logic [63:0] mean, m2, msq;
  logic        vflag;
  logic        fano_sat;

  // Shared 32x32 multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic [3:0]  target;
  logic [3:0]  empty;
  logic [28:0] decay_c, grow_c;
  assign target  = direction_mode ? 4'd0 : START4;
  assign empty   = (SITES4 > unit_count) ? SITES4 - unit_count : 4'd0;
  assign decay_c = 29'(unit_count * decay_rate);
  assign grow_c  = 29'(empty * growth_rate);

  logic [4:0] msb;
  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) if (rand_time[i]) msb = 5'(i);
  end

  logic [64:0] drem_sh;
  assign drem_sh = {drem[63:0], dnum[63]};

  // One restoring divide step, shared by all divides.
  logic        div_bit;
  logic [64:0] div_rem;
  logic [63:0] quo_next;
  assign div_bit  = drem_sh >= {1'b0, dden};
  assign div_rem  = div_bit ? drem_sh - {1'b0, dden} : drem_sh;
  assign quo_next = {dquo[62:0], div_bit};

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = (state == S_IDLE);

  logic [29:0] nl2;
  assign nl2 = {1'b1, 29'd0} - {1'b0, lpos, frac};

  logic [63:0] sq_sum;
  logic [47:0] et_sum;

  always_comb begin
    mul_a = m[31:0];
    mul_b = m[31:0];
    case (state)
      S_LN:  begin mul_a = {2'd0, nl2}; mul_b = LN2_Q32; end
      S_DIR: begin mul_a = r2; mul_b = 32'(total); end
      S_SQA: begin mul_a = elapsed_time[31:0]; mul_b = elapsed_time[31:0]; end
      S_SQB: begin mul_a = elapsed_time[31:0]; mul_b = {16'd0, elapsed_time[47:32]}; end
      S_SQC: begin mul_a = {16'd0, elapsed_time[47:32]};
                   mul_b = {16'd0, elapsed_time[47:32]}; end
      S_MSQA: begin mul_a = mean[31:0]; mul_b = mean[31:0]; end
      S_MSQB: begin mul_a = mean[31:0]; mul_b = {16'd0, mean[47:32]}; end
      S_MSQC: begin mul_a = {16'd0, mean[47:32]}; mul_b = {16'd0, mean[47:32]}; end
      default: ;
    endcase
  end

  assign et_sum  = elapsed_time;
  assign sq_sum  = time_square_sum;

  logic [64:0] tsum_w, ssum_w;
  assign tsum_w = {1'b0, time_sum} + {17'd0, et_sum};
  assign ssum_w = {1'b0, sq_sum} + {1'b0, acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      decay_rate <= 24'd335544;
      growth_rate <= '0;
      direction_mode <= 1'b1;
      num_runs <= 16'd40000;
      unit_count <= START4;
      elapsed_time <= '0;
      runs_done <= '0;
      time_sum <= '0;
      time_square_sum <= '0;
      overflow_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DECAY:  decay_rate <= cfg_data;
          REG_GROWTH: growth_rate <= cfg_data;
          REG_DIR: begin
            direction_mode <= cfg_data[0];
            unit_count <= cfg_data[0] ? START4 : 4'd0;
            elapsed_time <= '0;
          end
          REG_RUNS:   num_runs <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid && in_ready && rand_time != 0 && rand_dir != 0) begin
          r2 <= rand_dir;
          lpos <= msb;
          m <= {1'b0, rand_time << (5'd31 - msb)};
          state <= S_RATE;
        end
        S_RATE: begin
          decay <= decay_c;
          total <= decay_c + grow_c;
          frac <= '0;
          cnt <= '0;
          if (decay_c + grow_c == 0) begin
            elapsed_time <= MASK48;
            overflow_seen <= 1'b1;
            state <= S_IDLE;
          end else state <= S_LOGM;
        end
        S_LOGM: begin
          m <= mul_p[63:31];
          state <= S_LOGN;
        end
        S_LOGN: begin
          if (m[32]) begin
            m <= {1'b0, m[32:1]};
            frac <= {frac[22:0], 1'b1};
          end else frac <= {frac[22:0], 1'b0};
          cnt <= cnt + 5'd1;
          state <= (cnt == 5'd23) ? S_LN : S_LOGM;
        end
        S_LN: begin
          // e = nl2*ln2 >> 24; dividend = e << 8, so its low 8 bits are zero.
          dnum <= {16'd0, mul_p[63:24], 8'd0};
          dden <= {35'd0, total};
          drem <= '0;
          dcnt <= '0;
          state <= S_DIVR;
        end
        S_DIVR: begin
          drem <= div_rem;
          dquo <= quo_next;
          dnum <= {dnum[62:0], 1'b0};
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd63) state <= S_DIR;
        end
        S_DIR: begin
          if ({1'b0, elapsed_time} + {1'b0, dquo[47:0]} > {1'b0, MASK48} ||
              dquo[63:48] != 0) begin
            elapsed_time <= MASK48;
            overflow_seen <= 1'b1;
          end else elapsed_time <= elapsed_time + dquo[47:0];
          if (mul_p < {3'd0, decay, 32'd0}) unit_count <= unit_count - 4'd1;
          else unit_count <= unit_count + 4'd1;
          state <= S_ADV;
        end
        S_ADV: begin
          if (unit_count == target) begin
            acc <= '0;
            sat <= 1'b0;
            state <= S_SQA;
          end else state <= S_IDLE;
        end
        S_SQA: begin acc <= mul_p; state <= S_SQB; end
        S_SQB: begin
          // lo + 2*mid*2^32; track carries into the high word.
          acc <= acc + {mul_p[30:0], 33'd0};
          sat_hi <= 2'(({1'b0, acc} + {1'b0, mul_p[30:0], 33'd0}) >> 64);
          dnum <= {31'd0, mul_p[63:31]};
          state <= S_SQC;
        end
        S_SQC: begin
          dnum <= dnum + mul_p + 64'(sat_hi);
          state <= S_SQD;
        end
        S_SQD: begin
          // dnum holds the high word of the 96-bit square.
          if (dnum[63:16] != 0) begin
            acc <= '1;
            sat <= 1'b1;
          end else acc <= {dnum[15:0], acc[63:16]};
          state <= S_SUM;
        end
        S_SUM: begin
          time_sum <= tsum_w[64] ? '1 : tsum_w[63:0];
          time_square_sum <= ssum_w[64] ? '1 : ssum_w[63:0];
          sat <= sat || tsum_w[64] || ssum_w[64];
          runs_done <= runs_done + 16'd1;
          passage_time <= elapsed_time;
          run_index <= runs_done + 16'd1;
          batch_end <= (runs_done + 16'd1) >= ((num_runs == 0) ? 16'd1 : num_runs);
          state <= S_MEAN;
        end
        S_MEAN: begin
          if (sat) overflow_seen <= 1'b1;
          if (!batch_end) begin
            batch_done <= 1'b0;
            mean_time <= '0;
            time_variance <= '0;
            fano_ratio <= '0;
            time_overflow <= overflow_seen || sat;
            state <= S_OUT;
          end else begin
            dnum <= time_sum;
            dden <= {48'd0, runs_done};
            drem <= '0;
            dcnt <= '0;
            vflag <= 1'b0;
            state <= S_M2;
          end
        end
        S_M2: begin
          // Bit-serial divide reused: first mean, then second moment.
          dquo <= quo_next;
          if (dcnt == 7'd63) begin
            dcnt <= '0;
            drem <= '0;
            if (vflag) begin
              m2 <= quo_next;
              state <= S_MSQA;
            end else begin
              mean <= (quo_next[63:48] != 0) ? {16'd0, MASK48}
                      : {16'd0, quo_next[47:0]};
              dnum <= time_square_sum;
              vflag <= 1'b1;
            end
          end else begin
            drem <= div_rem;
            dnum <= {dnum[62:0], 1'b0};
            dcnt <= dcnt + 7'd1;
          end
        end
        S_MSQA: begin acc <= mul_p; vflag <= 1'b0; state <= S_MSQB; end
        S_MSQB: begin
          acc <= acc + {mul_p[30:0], 33'd0};
          sat_hi <= 2'(({1'b0, acc} + {1'b0, mul_p[30:0], 33'd0}) >> 64);
          dnum <= {31'd0, mul_p[63:31]};
          state <= S_MSQC;
        end
        S_MSQC: begin dnum <= dnum + mul_p + 64'(sat_hi); state <= S_MSQD; end
        S_MSQD: begin
          msq <= (dnum[63:16] != 0) ? '1 : {dnum[15:0], acc[63:16]};
          state <= S_VAR;
        end
        S_VAR: begin
          logic [63:0] v;
          v = (m2 > msq) ? m2 - msq : '0;
          if (v[63]) begin
            v = {1'b0, MASK63};
            vflag <= 1'b1;
          end
          time_variance <= v[62:0];
          batch_done <= 1'b1;
          mean_time <= mean[47:0];
          dnum <= v;
          dden <= msq;
          drem <= '0;
          dcnt <= '0;
          fano_sat <= 1'b0;
          state <= S_FANO;
        end
        S_FANO: begin
          // 64 integer steps + 16 fraction steps, 65-bit remainder.
          // A one among the first 48 quotient bits means the ratio saturates.
          drem <= div_rem;
          dquo <= quo_next;
          dnum <= {dnum[62:0], 1'b0};
          dcnt <= dcnt + 7'd1;
          if (div_bit && dcnt <= 7'd47) fano_sat <= 1'b1;
          if (dcnt == 7'd79) begin
            if (msq == 0 || fano_sat) fano_ratio <= '1;
            else fano_ratio <= quo_next[31:0];
            time_overflow <= overflow_seen || vflag;
            runs_done <= '0;
            time_sum <= '0;
            time_square_sum <= '0;
            overflow_seen <= 1'b0;
            vflag <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          unit_count <= direction_mode ? START4 : 4'd0;
          elapsed_time <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BD_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE, "ready outside idle")
  `BD_ASSERT_IMP(a_no_accept_busy, clk, rst, out_valid, !in_ready, "accept while result held")
  `BD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `BD_ASSERT_IMP(a_done_index, clk, rst, out_valid && batch_done, run_index != 0, "bad batch index")
endmodule
